// File: sv/haversine_distance_eta_unit_macros.svh
// assertion helpers used by the rtl fifo
`ifndef HAVERSINE_DISTANCE_ETA_UNIT_MACROS_SVH
`define HAVERSINE_DISTANCE_ETA_UNIT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define HDE_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define HDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/hde_pkg.sv
`default_nettype none

package hde_pkg;

    localparam logic [29:0] DEG_FULL    = 30'd754974720;
    localparam logic [27:0] DEG_QUARTER = 28'd188743680;
    localparam logic [14:0] RAD_MUL_HI  = 15'd18301;
    localparam logic [14:0] RAD_MUL_LO  = 15'd3397;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [30:0] Q_ONE       = 31'h4000_0000;
    localparam logic [23:0] EARTH_2R_M  = 24'd12742000;
    localparam logic [24:0] MAX_DIST    = 25'd20015087;
    // ceil(2^34 / 500), exact floor for any 25-bit distance
    localparam logic [25:0] MIN_RECIP   = 26'd34359739;
    localparam int          SQRT_STEPS  = 32;
    localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic [1:0]  quad;
        logic [27:0] rem;
    } angle_t;

    typedef struct packed {
        angle_t      dlat;
        angle_t      dlon;
        angle_t      lat1;
        angle_t      lat2;
        logic [24:0] radius;
    } job_t;

    typedef struct packed {
        logic [24:0] distance;
        logic [15:0] eta;
        logic        near;
    } result_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } vec_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } sq_t;

    // arctangent of 2^-k, radians q30
    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // rotation mode step, drives z toward zero
    function automatic rot_t rot_step(input rot_t s, input logic [4:0] k);
        rot_t o;
        logic signed [32:0] at;
        at = $signed({1'b0, atan_q30(k)});
        if (!s.z[32])
        begin
            o.x = s.x - (s.y >>> k);
            o.y = s.y + (s.x >>> k);
            o.z = s.z - at;
        end
        else
        begin
            o.x = s.x + (s.y >>> k);
            o.y = s.y - (s.x >>> k);
            o.z = s.z + at;
        end
        return o;
    endfunction

    // vectoring mode step, drives y toward zero
    function automatic vec_t vec_step(input vec_t s, input logic [4:0] k);
        vec_t o;
        logic signed [33:0] at;
        at = $signed({2'b00, atan_q30(k)});
        if (!s.y[33])
        begin
            o.x = s.x + (s.y >>> k);
            o.y = s.y - (s.x >>> k);
            o.z = s.z + at;
        end
        else
        begin
            o.x = s.x - (s.y >>> k);
            o.y = s.y + (s.x >>> k);
            o.z = s.z - at;
        end
        return o;
    endfunction

    // one digit of the integer square root recurrence
    function automatic sq_t sqrt_step(input sq_t s, input logic [63:0] b);
        sq_t o;
        logic [63:0] t;
        t = s.root + b;
        if (s.rem >= t)
        begin
            o.rem  = s.rem - t;
            o.root = (s.root >> 1) + b;
        end
        else
        begin
            o.rem  = s.rem;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // magnitude clamped to one
    function automatic logic [30:0] mag_q30(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return (m > 33'(Q_ONE)) ? Q_ONE : m[30:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/haversine_distance_eta_unit.sv
// channel   | handshake           | fields
// ----------+---------------------+-----------------------------------------------
// query in  | push / full         | from_lat, from_lon, to_lat, to_lon, radius_m
// result out| empty / pop         | distance_m, eta_minutes, is_near
//
// one query is taken every cycle while full is low; the back pipe is fully
// pipelined, one cordic or square root digit per stage
// reset is asynchronous and active low, clears all valid bits and queue pointers
// a full result queue freezes the back pipe whenever its last stage holds a result;
// the mid queue then fills and full rises
`default_nettype none

module haversine_distance_eta_unit
    import hde_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [27:0] from_lat,
    input  logic signed [28:0] from_lon,
    input  logic signed [27:0] to_lat,
    input  logic signed [28:0] to_lon,
    input  logic [24:0]        radius_m,
    output logic               empty,
    input  logic               pop,
    output logic [24:0]        distance_m,
    output logic [15:0]        eta_minutes,
    output logic               is_near
);

    // short queues between front, back and the result port
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    job_t    front_job, mid_job;
    logic    front_valid, mid_full, mid_empty, mid_pop;
    logic [$bits(job_t)-1:0]    mid_rd_data;
    result_t back_res, out_res;
    logic    back_valid, out_full;
    logic [$bits(result_t)-1:0] out_rd_data;

    // front: angle differences, wrap to one turn, quadrant split
    hde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .from_lat  (from_lat),
        .from_lon  (from_lon),
        .to_lat    (to_lat),
        .to_lon    (to_lon),
        .radius_m  (radius_m),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (!mid_full)
    );

    // decouples front from back stalls
    hde_fifo #(.WIDTH($bits(job_t)), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (front_valid),
        .wr_data (front_job),
        .full    (mid_full),
        .rd      (mid_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign mid_job = mid_rd_data;

    // back: sin/cos, haversine term, square roots, atan2, scaling
    hde_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (mid_job),
        .job_valid (!mid_empty),
        .job_pop   (mid_pop),
        .res       (back_res),
        .res_valid (back_valid),
        .res_full  (out_full)
    );

    // result skid queue, holds an item while the consumer stalls
    hde_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (back_valid),
        .wr_data (back_res),
        .full    (out_full),
        .rd      (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign out_res     = out_rd_data;
    assign distance_m  = out_res.distance;
    assign eta_minutes = out_res.eta;
    assign is_near     = out_res.near;

endmodule

`default_nettype wire

// File: sv/hde_fifo.sv
`default_nettype none
`include "haversine_distance_eta_unit_macros.svh"

module hde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    // depth is a power of two, pointers wrap on their own
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] CNT_MAX = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             wr_en, rd_en;

    assign full    = (count_reg == CNT_MAX);
    assign empty   = (count_reg == '0);
    assign wr_en   = wr && !full;
    assign rd_en   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `HDE_ASSERT_NEXT(a_cnt_up, wr_en && !rd_en, count_reg == $past(count_reg) + 1'b1, "count missed a write")
    `HDE_ASSERT_NEXT(a_cnt_down, rd_en && !wr_en, count_reg == $past(count_reg) - 1'b1, "count missed a read")
    `HDE_ASSERT_HOLDS(a_cnt_max, count_reg <= CNT_MAX, "count beyond depth")
    `HDE_ASSERT_HOLDS(a_ptr_gap, AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[AW-1:0], "pointers disagree with count")

endmodule

`default_nettype wire

// File: sv/hde_front.sv
`default_nettype none

module hde_front
    import hde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [27:0] from_lat,
    input  logic signed [28:0] from_lon,
    input  logic signed [27:0] to_lat,
    input  logic signed [28:0] to_lon,
    input  logic [24:0]        radius_m,
    output job_t               job,
    output logic               job_valid,
    input  logic               job_ready
);

    localparam logic [29:0] Q1 = {2'b00, DEG_QUARTER};
    localparam logic [29:0] Q2 = 30'd377487360;
    localparam logic [29:0] Q3 = 30'd566231040;

    // fold into [0, 360) degrees, inputs never reach a full turn
    function automatic logic [29:0] wrap_deg(input logic signed [30:0] v);
        logic signed [30:0] t;
        t = v[30] ? v + $signed({1'b0, DEG_FULL}) : v;
        return t[29:0];
    endfunction

    function automatic angle_t classify(input logic [29:0] a);
        angle_t o;
        logic [29:0] d;
        if (a >= Q3)
        begin
            o.quad = QUAD_3;
            d = a - Q3;
        end
        else if (a >= Q2)
        begin
            o.quad = QUAD_2;
            d = a - Q2;
        end
        else if (a >= Q1)
        begin
            o.quad = QUAD_1;
            d = a - Q1;
        end
        else
        begin
            o.quad = QUAD_0;
            d = a;
        end
        o.rem = d[27:0];
        return o;
    endfunction

    logic        valid_reg;
    logic        adv;
    logic [29:0] dlat_reg, dlon_reg, lat1_reg, lat2_reg;
    logic [29:0] dlat_next, dlon_next, lat1_next, lat2_next;
    logic [24:0] radius_reg;

    assign adv  = !valid_reg || job_ready;
    assign full = !adv;

    // half-angle differences and doubled latitudes, all in 2^-21 degree
    assign dlat_next = wrap_deg(31'(to_lat) - 31'(from_lat));
    assign dlon_next = wrap_deg(31'(to_lon) - 31'(from_lon));
    assign lat1_next = wrap_deg(31'(from_lat) + 31'(from_lat));
    assign lat2_next = wrap_deg(31'(to_lat) + 31'(to_lat));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlat_reg   <= dlat_next;
            dlon_reg   <= dlon_next;
            lat1_reg   <= lat1_next;
            lat2_reg   <= lat2_next;
            radius_reg <= radius_m;
        end
    end

    assign job_valid  = valid_reg;
    assign job.dlat   = classify(dlat_reg);
    assign job.dlon   = classify(dlon_reg);
    assign job.lat1   = classify(lat1_reg);
    assign job.lat2   = classify(lat2_reg);
    assign job.radius = radius_reg;

endmodule

`default_nettype wire

// File: sv/hde_sincos.sv
`default_nettype none

module hde_sincos
    import hde_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic               clk,
    input  logic               en,
    input  angle_t             ang,
    output logic signed [32:0] sin_o,
    output logic signed [32:0] cos_o
);

    logic [42:0] phi_reg, plo_reg;
    logic [1:0]  qa_reg, qb_reg;
    logic [30:0] zb_reg;
    logic [57:0] zsum;
    rot_t        st0;
    rot_t        st_reg [1:STEPS];
    logic [1:0]  q_reg [1:STEPS];
    logic signed [32:0] s, c;

    // degrees to radians q30, constant split in two 15-bit halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg <= ang.rem * RAD_MUL_HI;
            plo_reg <= ang.rem * RAD_MUL_LO;
            qa_reg  <= ang.quad;
        end
    end

    assign zsum = {phi_reg, 15'd0} + {15'd0, plo_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zb_reg <= zsum[56:26];
            qb_reg <= qa_reg;
        end
    end

    assign st0 = '{x: CORDIC_GAIN, y: 33'sd0, z: $signed({2'b00, zb_reg})};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        rot_t       src;
        logic [1:0] qsrc;
        if (i == 0)
        begin : g_first
            assign src  = st0;
            assign qsrc = qb_reg;
        end
        else
        begin : g_rest
            assign src  = st_reg[i];
            assign qsrc = q_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i+1] <= rot_step(src, 5'(i));
                q_reg[i+1]  <= qsrc;
            end
        end
    end

    assign s = st_reg[STEPS].y;
    assign c = st_reg[STEPS].x;

    always_comb
    begin
        case (q_reg[STEPS])
            QUAD_0:
            begin
                sin_o = s;
                cos_o = c;
            end
            QUAD_1:
            begin
                sin_o = c;
                cos_o = -s;
            end
            QUAD_2:
            begin
                sin_o = -s;
                cos_o = -c;
            end
            default:
            begin
                sin_o = -c;
                cos_o = s;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/hde_back.sv
`default_nettype none

module hde_back
    import hde_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  logic    job_valid,
    output logic    job_pop,
    output result_t res,
    output logic    res_valid,
    input  logic    res_full
);

    localparam int LAT     = 2 * STEPS + 40;
    localparam int RAD_LEN = LAT - 2;

    logic               adv;
    logic [LAT:1]       vld_reg;
    logic [24:0]        rad_reg [1:RAD_LEN];
    logic signed [32:0] s_dlat, s_dlon, c_lat1, c_lat2;

    // whole pipe holds when the last stage has an item and no room follows
    assign adv     = !(vld_reg[LAT] && res_full);
    assign job_pop = adv && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-1:1], job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[1] <= job.radius;
            for (int k = 2; k <= RAD_LEN; k++)
            begin
                rad_reg[k] <= rad_reg[k-1];
            end
        end
    end

    hde_sincos #(.STEPS(STEPS)) u_dlat (
        .clk(clk), .en(adv), .ang(job.dlat), .sin_o(s_dlat), .cos_o()
    );
    hde_sincos #(.STEPS(STEPS)) u_dlon (
        .clk(clk), .en(adv), .ang(job.dlon), .sin_o(s_dlon), .cos_o()
    );
    hde_sincos #(.STEPS(STEPS)) u_lat1 (
        .clk(clk), .en(adv), .ang(job.lat1), .sin_o(), .cos_o(c_lat1)
    );
    hde_sincos #(.STEPS(STEPS)) u_lat2 (
        .clk(clk), .en(adv), .ang(job.lat2), .sin_o(), .cos_o(c_lat2)
    );

    // squares and cosine product
    logic [30:0] m_dlat, m_dlon, m_lat1, m_lat2;
    logic [61:0] sl_prod, sx_prod, p_prod, term_prod;
    logic [30:0] sl_reg, sx_reg, p_reg, term_reg, sl2_reg;
    logic        neg_reg, neg2_reg, neg_next;

    assign m_dlat   = mag_q30(s_dlat);
    assign m_dlon   = mag_q30(s_dlon);
    assign m_lat1   = mag_q30(c_lat1);
    assign m_lat2   = mag_q30(c_lat2);
    assign sl_prod  = m_dlat * m_dlat;
    assign sx_prod  = m_dlon * m_dlon;
    assign p_prod   = m_lat1 * m_lat2;
    assign neg_next = c_lat1[32] ^ c_lat2[32];
    assign term_prod = p_reg * sx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_reg   <= sl_prod[60:30];
            sx_reg   <= sx_prod[60:30];
            p_reg    <= p_prod[60:30];
            neg_reg  <= neg_next;
            term_reg <= term_prod[60:30];
            sl2_reg  <= sl_reg;
            neg2_reg <= neg_reg;
        end
    end

    // haversine term clamped to [0, 1]
    logic signed [32:0] a_sum;
    logic [30:0]        a_next, a_reg;

    assign a_sum = neg2_reg ? $signed({2'b00, sl2_reg}) - $signed({2'b00, term_reg})
                            : $signed({2'b00, sl2_reg}) + $signed({2'b00, term_reg});

    always_comb
    begin
        if (a_sum[32])
        begin
            a_next = '0;
        end
        else if (a_sum > $signed({2'b00, Q_ONE}))
        begin
            a_next = Q_ONE;
        end
        else
        begin
            a_next = a_sum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
        end
    end

    // two square roots, one result digit per stage
    sq_t   sqa0, sqb0;
    sq_t   sqa_reg [1:SQRT_STEPS];
    sq_t   sqb_reg [1:SQRT_STEPS];
    logic [30:0] one_minus_a;

    assign one_minus_a = Q_ONE - a_reg;
    assign sqa0 = '{rem: {3'b000, a_reg, 30'd0}, root: 64'd0};
    assign sqb0 = '{rem: {3'b000, one_minus_a, 30'd0}, root: 64'd0};

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sq
        sq_t srca, srcb;
        if (i == 0)
        begin : g_first
            assign srca = sqa0;
            assign srcb = sqb0;
        end
        else
        begin : g_rest
            assign srca = sqa_reg[i];
            assign srcb = sqb_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sqa_reg[i+1] <= sqrt_step(srca, SQRT_TOP_BIT >> (2 * i));
                sqb_reg[i+1] <= sqrt_step(srcb, SQRT_TOP_BIT >> (2 * i));
            end
        end
    end

    // atan2 by vectoring
    vec_t vec0;
    vec_t vec_reg [1:STEPS];

    assign vec0 = '{x: $signed({3'b000, sqb_reg[SQRT_STEPS].root[30:0]}),
                    y: $signed({3'b000, sqa_reg[SQRT_STEPS].root[30:0]}),
                    z: 34'sd0};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_vec
        vec_t src;
        if (i == 0)
        begin : g_first
            assign src = vec0;
        end
        else
        begin : g_rest
            assign src = vec_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vec_reg[i+1] <= vec_step(src, 5'(i));
            end
        end
    end

    // angle to metres, saturate, minutes and radius check
    logic [31:0] zc;
    logic [55:0] dprod_reg;
    logic [25:0] dfl;
    logic [24:0] dist_next, dist_reg, dist3_reg;
    logic        near_next, near_reg, near3_reg;
    logic [50:0] eprod_reg;

    assign zc        = vec_reg[STEPS].z[33] ? 32'd0 : vec_reg[STEPS].z[31:0];
    assign dfl       = dprod_reg[55:30];
    assign dist_next = (dfl > {1'b0, MAX_DIST}) ? MAX_DIST : dfl[24:0];
    assign near_next = (dist_next <= rad_reg[RAD_LEN]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dprod_reg <= zc * EARTH_2R_M;
            dist_reg  <= dist_next;
            near_reg  <= near_next;
            eprod_reg <= dist_reg * MIN_RECIP;
            dist3_reg <= dist_reg;
            near3_reg <= near_reg;
        end
    end

    assign res_valid    = vld_reg[LAT];
    assign res.distance = dist3_reg;
    assign res.eta      = eprod_reg[49:34];
    assign res.near     = near3_reg;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import hde_pkg::*;

    localparam int STEPS = 24;
    // full-scale inputs and the saturation point
    localparam longint LAT_MAX  = 94371840;
    localparam longint LON_MAX  = 188743680;
    localparam longint RAD_MAX  = 20015087;
    localparam longint TWO_PI_DEG = 754974720;
    localparam longint QUARTER_DEG = 188743680;
    localparam longint Q30_ONE = 64'd1073741824;

    // one query as the sender presents it
    typedef struct {
        logic signed [27:0] from_lat;
        logic signed [28:0] from_lon;
        logic signed [27:0] to_lat;
        logic signed [28:0] to_lon;
        logic [24:0]        radius_m;
    } query_t;

    // one expected answer
    typedef struct {
        logic [24:0] distance_m;
        logic [15:0] eta_minutes;
        logic        is_near;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [27:0] from_lat = '0;
    logic signed [28:0] from_lon = '0;
    logic signed [27:0] to_lat = '0;
    logic signed [28:0] to_lon = '0;
    logic [24:0] radius_m = '0;
    logic [24:0] distance_m;
    logic [15:0] eta_minutes;
    logic is_near;

    query_t  pending_queries[$];
    answer_t awaited_answers[$];
    int      error_count = 0;
    // idle percentages per phase: sender, receiver
    int      send_idle_pct = 37;
    int      recv_idle_pct = 59;
    bit      hold_sender = 1'b0;
    bit      stimulus_done = 1'b0;

    always #4 clk = ~clk;

    haversine_distance_eta_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .from_lat(from_lat), .from_lon(from_lon), .to_lat(to_lat), .to_lon(to_lon),
        .radius_m(radius_m), .empty(empty), .pop(pop),
        .distance_m(distance_m), .eta_minutes(eta_minutes), .is_near(is_near)
    );

    // arithmetic shift right on a 64-bit value
    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_entry(int k);
        return longint'(atan_q30(5'(k)));
    endfunction

    // sine and cosine of an angle in 2^-21 degree units, q30
    function automatic void sin_cos_q30(longint ang, output longint sn, output longint cs);
        longint x, y, z, nx, ny, rem;
        int quad;
        ang = ang % TWO_PI_DEG;
        if (ang < 0)
        begin
            ang += TWO_PI_DEG;
        end
        quad = int'(ang / QUARTER_DEG) & 3;
        rem = ang - longint'(quad) * QUARTER_DEG;
        z = (rem * 64'd599690565) >>> 26;
        x = 64'd652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shr_arith(y, i % 32);
                ny = y + shr_arith(x, i % 32);
                z -= arctan_entry(i % 32);
            end
            else
            begin
                nx = x + shr_arith(y, i % 32);
                ny = y - shr_arith(x, i % 32);
                z += arctan_entry(i % 32);
            end
            x = nx;
            y = ny;
        end
        case (2'(quad))
            QUAD_0:  begin sn = y;  cs = x;  end
            QUAD_1:  begin sn = x;  cs = -y; end
            QUAD_2:  begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y;  end
        endcase
    endfunction

    function automatic longint clamp_mag(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return (m > Q30_ONE) ? Q30_ONE : m;
    endfunction

    // floor integer square root by digit recurrence
    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] rem, root, bitv;
        rem = v;
        root = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // distance, travel time and proximity for one query
    function automatic answer_t great_circle(query_t q);
        answer_t ans;
        longint fl, fo, tl, to_l, s1, s2, c1, c2, unused;
        longint m1, m2, sl, sx, p, term, hav, x, y, z, nx, ny;
        logic [63:0] dist_val;
        fl = q.from_lat;
        fo = q.from_lon;
        tl = q.to_lat;
        to_l = q.to_lon;
        sin_cos_q30(tl - fl, s1, unused);
        sin_cos_q30(to_l - fo, s2, unused);
        sin_cos_q30(fl * 2, unused, c1);
        sin_cos_q30(tl * 2, unused, c2);
        m1 = clamp_mag(s1);
        sl = (m1 * m1) >>> 30;
        m2 = clamp_mag(s2);
        sx = (m2 * m2) >>> 30;
        p = (clamp_mag(c1) * clamp_mag(c2)) >>> 30;
        term = (p * sx) >>> 30;
        // opposite cosine signs subtract the longitude term
        hav = ((c1 < 0) != (c2 < 0)) ? sl - term : sl + term;
        if (hav < 0)
        begin
            hav = 0;
        end
        if (hav > Q30_ONE)
        begin
            hav = Q30_ONE;
        end
        y = int_sqrt(64'(hav) << 30);
        x = int_sqrt(64'(Q30_ONE - hav) << 30);
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + shr_arith(y, i % 32);
                ny = y - shr_arith(x, i % 32);
                z += arctan_entry(i % 32);
            end
            else
            begin
                nx = x - shr_arith(y, i % 32);
                ny = y + shr_arith(x, i % 32);
                z -= arctan_entry(i % 32);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
        begin
            z = 0;
        end
        dist_val = (64'(z) * 64'd12742000) >> 30;
        if (dist_val > RAD_MAX)
        begin
            dist_val = RAD_MAX;
        end
        ans.distance_m = dist_val[24:0];
        ans.eta_minutes = 16'(dist_val / 500);
        ans.is_near = (dist_val <= 64'(q.radius_m));
        return ans;
    endfunction

    function automatic query_t make_query(longint fl, longint fo, longint tl, longint tlo,
                                          longint rad);
        query_t q;
        q.from_lat = 28'(fl);
        q.from_lon = 29'(fo);
        q.to_lat = 28'(tl);
        q.to_lon = 29'(tlo);
        q.radius_m = 25'(rad);
        return q;
    endfunction

    // random query: mostly in-range, sometimes raw bit patterns, sometimes near pairs
    function automatic query_t random_query();
        query_t q;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            q.from_lat = 28'($urandom);
            q.from_lon = 29'($urandom);
            q.to_lat = 28'($urandom);
            q.to_lon = 29'($urandom);
        end
        else
        begin
            q.from_lat = 28'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            q.from_lon = 29'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
            if (mode <= 3)
            begin
                // nearby destination so the proximity flag toggles often
                q.to_lat = q.from_lat + 28'(int'($urandom_range(0, 200000)) - 100000);
                q.to_lon = q.from_lon + 29'(int'($urandom_range(0, 200000)) - 100000);
            end
            else
            begin
                q.to_lat = 28'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
                q.to_lon = 29'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
            end
        end
        case ($urandom_range(0, 3))
            0:       q.radius_m = 25'($urandom);
            1:       q.radius_m = 25'($urandom_range(0, 50000));
            default: q.radius_m = 25'($urandom_range(0, RAD_MAX));
        endcase
        return q;
    endfunction

    // driver: pending queue to the push side
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            awaited_answers.push_back(great_circle(pending_queries.pop_front()));
        end
        if (rst_n && !hold_sender && pending_queries.size() > 0 &&
            !(push && !full && pending_queries.size() == 0) &&
            $urandom_range(0, 99) >= send_idle_pct)
        begin
            query_t q;
            q = pending_queries[0];
            push <= 1'b1;
            from_lat <= q.from_lat;
            from_lon <= q.from_lon;
            to_lat <= q.to_lat;
            to_lon <= q.to_lon;
            radius_m <= q.radius_m;
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // monitor: compare each popped item against the oldest expectation
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("unexpected item: distance_m %0d", distance_m);
                error_count++;
            end
            else
            begin
                answer_t e;
                e = awaited_answers.pop_front();
                if (distance_m !== e.distance_m)
                begin
                    $error("distance_m expected %0d actual %0d", e.distance_m, distance_m);
                    error_count++;
                end
                if (eta_minutes !== e.eta_minutes)
                begin
                    $error("eta_minutes expected %0d actual %0d", e.eta_minutes, eta_minutes);
                    error_count++;
                end
                if (is_near !== e.is_near)
                begin
                    $error("is_near expected %0d actual %0d", e.is_near, is_near);
                    error_count++;
                end
            end
        end
        pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        int per_phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, identical points, antipodes, wrap-around, bad latitudes
        pending_queries.push_back(make_query(0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, RAD_MAX));
        pending_queries.push_back(make_query(0, 0, 0, LON_MAX, 0));
        pending_queries.push_back(make_query(LAT_MAX, 0, -LAT_MAX, 0, RAD_MAX));
        pending_queries.push_back(make_query(0, -LON_MAX, 0, LON_MAX, 1));
        pending_queries.push_back(make_query(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0));
        pending_queries.push_back(make_query(10485760, 0, 10485760, 1, 0));
        pending_queries.push_back(make_query(0, 0, 1, 0, 0));
        pending_queries.push_back(make_query(-134217728, -268435456, 134217727, 268435455,
                                             33554431));
        pending_queries.push_back(make_query(134217727, 268435455, -134217728, -268435456,
                                             0));
        pending_queries.push_back(make_query(-1, -1, -1, -1, 33554431));
        pending_queries.push_back(make_query(52428800, 10485760, 52428800, 10590618, 1000));
        pending_queries.push_back(make_query(52428800, 10485760, 52428800, 10590618, 100000));
        pending_queries.push_back(make_query(0, 94371840, 0, -94371840, RAD_MAX));
        pending_queries.push_back(make_query(47185920, 0, 47185920, LON_MAX, 12345678));

        per_phase = 500;
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < per_phase; i++)
            begin
                pending_queries.push_back(random_query());
            end
            while (pending_queries.size() > 0)
            begin
                @(posedge clk);
                // sender holds off until the pipe drains, once, midway through phase one
                if (phase == 0 && pending_queries.size() == per_phase / 2 && !hold_sender)
                begin
                    hold_sender = 1'b1;
                    while (awaited_answers.size() > 0 || push)
                    begin
                        @(posedge clk);
                    end
                    hold_sender = 1'b0;
                end
            end
            if (phase == 0)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        while (push || awaited_answers.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
        if (error_count == 0 && awaited_answers.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: haversine_distance_eta_unit.f
+incdir+sv
sv/hde_pkg.sv
sv/hde_fifo.sv
sv/hde_front.sv
sv/hde_sincos.sv
sv/hde_back.sv
sv/haversine_distance_eta_unit.sv
sim/tb_top.sv
